FILE: rtl/fqpd_pkg.sv
// Package for the fetch queue / predict / dispatch block.
// Holds widths, opcode and command codes, and the instruction decode function.
`default_nettype none
package fqpd_pkg;
    localparam int QueueDepth = 16;
    localparam int IdxW = $clog2(QueueDepth);

    localparam logic [6:0] OpcLui    = 7'h37;
    localparam logic [6:0] OpcAuipc  = 7'h17;
    localparam logic [6:0] OpcJal    = 7'h6f;
    localparam logic [6:0] OpcJalr   = 7'h67;
    localparam logic [6:0] OpcBranch = 7'h63;
    localparam logic [6:0] OpcLoad   = 7'h03;
    localparam logic [6:0] OpcStore  = 7'h23;
    localparam logic [6:0] OpcOpImm  = 7'h13;
    localparam logic [6:0] OpcOp     = 7'h33;
    localparam logic [31:0] ExitWord = 32'h0ff00513;

    localparam logic [2:0] KindReg = 3'd0;
    localparam logic [2:0] KindBranch = 3'd1;
    localparam logic [2:0] KindJalr = 3'd2;
    localparam logic [2:0] KindStoreB = 3'd3;
    localparam logic [2:0] KindExit = 3'd6;

    localparam logic [4:0] SopAdd = 5'd0, SopSub = 5'd1, SopAnd = 5'd2, SopOr = 5'd3;
    localparam logic [4:0] SopXor = 5'd4, SopShl = 5'd5, SopShr = 5'd6, SopSra = 5'd7;
    localparam logic [4:0] SopLt = 5'd8, SopLtu = 5'd9, SopEq = 5'd10, SopNe = 5'd11;
    localparam logic [4:0] SopGe = 5'd12, SopGeu = 5'd13, SopLb = 5'd14, SopLh = 5'd15;
    localparam logic [4:0] SopLw = 5'd16, SopLbu = 5'd17, SopLhu = 5'd18, SopSb = 5'd19;

    localparam logic [1:0] FormRR = 2'd0, FormRI = 2'd1, FormRRI = 2'd2;

    typedef struct packed {
        logic        issued;
        logic [2:0]  rob_kind;
        logic [31:0] rob_value;
        logic [31:0] rob_dest;
        logic [31:0] entry_pc;
        logic        value_ready;
        logic [4:0]  station_op;
        logic [1:0]  operand_form;
        logic [4:0]  first_operand;
        logic [31:0] second_operand;
        logic [31:0] third_operand;
        logic [31:0] fetch_pc;
    } t_result;

    typedef struct packed {
        logic      known;
        logic      mem;
        t_result   res;
    } t_decode;

    // Integer ALU op for funct3 of OP/OP-IMM
    function automatic logic [4:0] alu_op(input logic [2:0] f3);
        logic [4:0] op;
        unique case (f3)
            3'd0: op = SopAdd;
            3'd1: op = SopShl;
            3'd2: op = SopLt;
            3'd3: op = SopLtu;
            3'd4: op = SopXor;
            3'd5: op = SopShr;
            3'd6: op = SopOr;
            default: op = SopAnd;
        endcase
        return op;
    endfunction

    // Decode one queue entry into ROB and station commands
    function automatic t_decode decode(input logic [31:0] w, input logic [31:0] pc,
                                       input logic taken, input logic [4:0] lsu);
        t_decode d;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] imm_i, imm_s, imm_b;
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        d = '0;
        d.known = 1'b1;
        d.res.entry_pc = pc;
        d.res.rob_dest = {27'd0, w[11:7]};
        unique case (w[6:0])
            OpcLui: begin
                d.res.rob_value = {w[31:12], 12'd0};
                d.res.value_ready = 1'b1;
            end
            OpcAuipc: begin
                d.res.rob_value = pc + {w[31:12], 12'd0};
                d.res.value_ready = 1'b1;
            end
            OpcJal: begin
                d.res.rob_value = pc + 32'd4;
                d.res.value_ready = 1'b1;
            end
            OpcJalr: begin
                d.known = (f3 == 3'd0);
                d.res.rob_kind = KindJalr;
                d.res.operand_form = FormRI;
                d.res.first_operand = w[19:15];
                d.res.second_operand = imm_i;
            end
            OpcBranch: begin
                d.known = (f3 != 3'd2) && (f3 != 3'd3);
                d.res.rob_kind = KindBranch;
                d.res.rob_value = {31'd0, taken};
                d.res.rob_dest = pc + imm_b;
                unique case (f3)
                    3'd0: d.res.station_op = SopEq;
                    3'd1: d.res.station_op = SopNe;
                    3'd4: d.res.station_op = SopLt;
                    3'd5: d.res.station_op = SopGe;
                    3'd6: d.res.station_op = SopLtu;
                    default: d.res.station_op = SopGeu;
                endcase
                d.res.operand_form = FormRR;
                d.res.first_operand = w[19:15];
                d.res.second_operand = {27'd0, w[24:20]};
            end
            OpcLoad: begin
                d.known = (f3 != 3'd3) && (f3 != 3'd6) && (f3 != 3'd7);
                d.mem = 1'b1;
                d.res.rob_value = {27'd0, lsu};
                unique case (f3)
                    3'd0: d.res.station_op = SopLb;
                    3'd1: d.res.station_op = SopLh;
                    3'd2: d.res.station_op = SopLw;
                    3'd4: d.res.station_op = SopLbu;
                    default: d.res.station_op = SopLhu;
                endcase
                d.res.operand_form = FormRI;
                d.res.first_operand = w[19:15];
                d.res.second_operand = imm_i;
            end
            OpcStore: begin
                d.known = (f3 <= 3'd2);
                d.mem = 1'b1;
                d.res.rob_kind = KindStoreB + f3;
                d.res.rob_value = {27'd0, lsu};
                d.res.station_op = SopSb + {2'd0, f3};
                d.res.operand_form = FormRRI;
                d.res.first_operand = w[24:20];
                d.res.second_operand = {27'd0, w[19:15]};
                d.res.third_operand = imm_s;
            end
            OpcOpImm: begin
                d.res.operand_form = FormRI;
                d.res.first_operand = w[19:15];
                if (f3 == 3'd1 || f3 == 3'd5) begin
                    d.known = (f7 == 7'h00) || (f3 == 3'd5 && f7 == 7'h20);
                    d.res.station_op = (f7 == 7'h20) ? SopSra : alu_op(f3);
                    d.res.second_operand = {27'd0, w[24:20]};
                end else begin
                    d.res.station_op = alu_op(f3);
                    d.res.second_operand = imm_i;
                end
            end
            OpcOp: begin
                d.res.operand_form = FormRR;
                d.res.first_operand = w[19:15];
                d.res.second_operand = {27'd0, w[24:20]};
                if (f7 == 7'h00) d.res.station_op = alu_op(f3);
                else if (f7 == 7'h20 && f3 == 3'd0) d.res.station_op = SopSub;
                else if (f7 == 7'h20 && f3 == 3'd5) d.res.station_op = SopSra;
                else d.known = 1'b0;
            end
            default: d.known = 1'b0;
        endcase
        if (w == ExitWord) begin
            d.res.rob_kind = KindExit;
            d.res.rob_value = '0;
            d.res.rob_dest = '0;
        end
        return d;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/fqpd_if.sv
// Valid/ready channel interfaces for the fetch queue block.
// Depends on fqpd_pkg for the result type.
`default_nettype none
interface fqpd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] fetch_word;
    logic        predict_taken;
    logic        rob_ready;
    logic        station_ready;
    logic        lsu_ready;
    logic [4:0]  lsu_slot;
    logic [31:0] flush_target;
    modport source(output valid, action, fetch_word, predict_taken, rob_ready,
                   station_ready, lsu_ready, lsu_slot, flush_target, input ready);
    modport sink(input valid, action, fetch_word, predict_taken, rob_ready,
                 station_ready, lsu_ready, lsu_slot, flush_target, output ready);
endinterface

interface fqpd_out_if;
    logic                 valid;
    logic                 ready;
    fqpd_pkg::t_result    data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/fqpd_ctrl.sv
// Controller: accepts input items and holds the result register handshake.
// Depends on fqpd_pkg.
`default_nettype none
module fqpd_ctrl (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output logic o_step
);
    import fqpd_pkg::*;
    typedef enum logic {S_EMPTY, S_FULL} t_state;
    t_state r_state;

    // Result slot free, or being drained this cycle
    assign o_in_ready  = (r_state == S_EMPTY) || i_out_ready;
    assign o_step      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            unique case (r_state)
                S_EMPTY: if (o_step) r_state <= S_FULL;
                S_FULL:  if (i_out_ready && !o_step) r_state <= S_EMPTY;
                default: r_state <= S_EMPTY;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/fqpd_dp.sv
// Datapath: instruction queue, fetch PC, issue decode and result register.
// Depends on fqpd_pkg.
`default_nettype none
module fqpd_dp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  wire                i_action,
    input  wire  [31:0]        i_fetch_word,
    input  wire                i_predict_taken,
    input  wire                i_rob_ready,
    input  wire                i_station_ready,
    input  wire                i_lsu_ready,
    input  wire  [4:0]         i_lsu_slot,
    input  wire  [31:0]        i_flush_target,
    output fqpd_pkg::t_result  o_result
);
    import fqpd_pkg::*;

    logic [QueueDepth-1:0] r_valid;
    logic [31:0] r_word  [QueueDepth];
    logic [31:0] r_pc    [QueueDepth];
    logic        r_taken [QueueDepth];
    logic [IdxW-1:0] r_head, r_tail;
    logic [31:0] r_fetch_pc;
    t_result r_result;

    t_decode d_head, d_fetch;
    logic do_issue, do_fetch;
    logic [31:0] n_fetch_pc, imm_b, imm_j;
    logic [QueueDepth-1:0] n_valid;
    t_result n_result;

    // Issue side decode of head entry
    always_comb begin
        d_head   = decode(r_word[r_head], r_pc[r_head], r_taken[r_head], i_lsu_slot);
        do_issue = r_valid[r_head] && i_rob_ready && i_station_ready && d_head.known &&
                   (!d_head.mem || i_lsu_ready);
    end

    // Fetch side validity and next PC prediction
    always_comb begin
        d_fetch  = decode(i_fetch_word, r_fetch_pc, i_predict_taken, 5'd0);
        do_fetch = !r_valid[r_tail] && d_fetch.known;
        imm_b = {{20{i_fetch_word[31]}}, i_fetch_word[7], i_fetch_word[30:25],
                 i_fetch_word[11:8], 1'b0};
        imm_j = {{12{i_fetch_word[31]}}, i_fetch_word[19:12], i_fetch_word[20],
                 i_fetch_word[30:21], 1'b0};
        if (i_fetch_word[6:0] == OpcBranch && i_predict_taken) n_fetch_pc = r_fetch_pc + imm_b;
        else if (i_fetch_word[6:0] == OpcJal) n_fetch_pc = r_fetch_pc + imm_j;
        else n_fetch_pc = r_fetch_pc + 32'd4;
    end

    // Next valid bits: head and tail never coincide when both move
    always_comb begin
        n_valid = r_valid;
        if (do_issue) n_valid[r_head] = 1'b0;
        if (do_fetch) n_valid[r_tail] = 1'b1;
    end

    // Next result
    always_comb begin
        n_result = '0;
        if (i_action) begin
            n_result.fetch_pc = i_flush_target;
        end else begin
            if (do_issue) begin
                n_result = d_head.res;
                n_result.issued = 1'b1;
            end
            n_result.fetch_pc = do_fetch ? n_fetch_pc : r_fetch_pc;
        end
    end

    // Queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_fetch_pc <= '0;
        end else if (i_step) begin
            if (i_action) begin
                r_valid <= '0;
                r_head <= '0;
                r_tail <= '0;
                r_fetch_pc <= i_flush_target;
            end else begin
                r_valid <= n_valid;
                if (do_issue) begin
                    r_head <= r_head + 1'b1;
                end
                if (do_fetch) begin
                    r_tail <= r_tail + 1'b1;
                    r_fetch_pc <= n_fetch_pc;
                end
            end
        end
    end

    // Queue payload and result register
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (!i_action && do_fetch) begin
                r_word[r_tail]  <= i_fetch_word;
                r_pc[r_tail]    <= r_fetch_pc;
                r_taken[r_tail] <= i_predict_taken;
            end
            r_result <= n_result;
        end
    end

    assign o_result = r_result;
endmodule
`default_nettype wire

FILE: rtl/fetch_queue_predict_dispatch_core.sv
// Fetch queue with branch prediction and in-order dispatch.
// Input channel carries one tick or flush per transfer; output channel one
// result per transfer. Each accepted tick both tries to issue the queue head
// (toward ROB and station) and tries to fetch the supplied word into the tail.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one item per cycle while results are taken; the single result
// register is the only buffering, and it is refilled in the same cycle it drains.
// A stalled receiver holds the result and stops input acceptance until the
// result is taken. Synchronous active-low reset empties the queue, zeroes the
// head, tail and fetch PC, and leaves no result pending. The 16-entry queue
// is held in registers with per-entry valid bits.
// Depends on fqpd_pkg, fqpd_if, fqpd_ctrl, fqpd_dp.
`default_nettype none
module fetch_queue_predict_dispatch_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fqpd_in_if.sink     i_in,
    fqpd_out_if.source  o_out
);
    import fqpd_pkg::*;
    logic step;

    fqpd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_step(step)
    );

    fqpd_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_action(i_in.action), .i_fetch_word(i_in.fetch_word),
        .i_predict_taken(i_in.predict_taken), .i_rob_ready(i_in.rob_ready),
        .i_station_ready(i_in.station_ready), .i_lsu_ready(i_in.lsu_ready),
        .i_lsu_slot(i_in.lsu_slot), .i_flush_target(i_in.flush_target),
        .o_result(o_out.data)
    );
endmodule
`default_nettype wire

FILE: rtl/fqpd_checker.sv
// Port-level checker for the fetch queue block, bound to the top level.
// Depends on fqpd_pkg and the channel interfaces.
`default_nettype none
module fqpd_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_in_valid,
    input wire         i_in_ready,
    input wire         i_in_action,
    input wire         i_out_valid,
    input wire         i_out_ready,
    input wire         i_out_issued,
    input wire [4:0]   i_out_op
);
    // Accepted input always yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid) else $error("missing result");
    // Flush never issues
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action |=> !i_out_issued)
        else $error("issue on flush");
    // Nothing issues straight after a flush
    a_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action ##1 i_in_valid && i_in_ready |=> !i_out_issued)
        else $error("issue from empty queue");
    // Non-issued result carries no station op
    a_idle_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_issued |-> i_out_op == 5'd0) else $error("stray op");
    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("result dropped");
endmodule

bind fetch_queue_predict_dispatch_core fqpd_checker u_fqpd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready), .i_in_action(i_in.action),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_issued(o_out.data.issued), .i_out_op(o_out.data.station_op)
);
`default_nettype wire

FILE: tb/sv/fqpd_queue_checker.sv
// Checker for the fetch queue / predict / dispatch block: watches both channels,
// models the instruction queue and compares each result transfer in order.
// Depends on fqpd_pkg and fqpd_if.
module fqpd_queue_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fqpd_in_if         i_in,
    fqpd_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending
);
    import fqpd_pkg::*;

    localparam logic [2:0] F3Sra = 3'd5;
    localparam logic [6:0] F7Alt = 7'h20;

    logic        q_valid [QueueDepth];
    logic [31:0] q_word  [QueueDepth];
    logic [31:0] q_pc    [QueueDepth];
    logic        q_taken [QueueDepth];
    logic [IdxW-1:0] head_ptr, tail_ptr;
    logic [31:0] pc_next;
    t_result     expected_results[$];
    int          fails;

    assign o_fail_count = fails;

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] r;
        r = v;
        for (int b = bits; b < 32; b++) r[b] = v[bits-1];
        return r;
    endfunction

    function automatic logic [4:0] alu_code(input logic [2:0] f3);
        case (f3)
            3'd0: return SopAdd;
            3'd1: return SopShl;
            3'd2: return SopLt;
            3'd3: return SopLtu;
            3'd4: return SopXor;
            3'd5: return SopShr;
            3'd6: return SopOr;
            default: return SopAnd;
        endcase
    endfunction

    // Decode one word into rob/station commands; known=0 for illegal words
    function automatic void decode_word(input logic [31:0] w, input logic [31:0] pc,
                                        input logic tk, input logic [4:0] lsu,
                                        output logic known, output logic mem,
                                        output t_result r);
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] ii, is, ib;
        f3 = w[14:12];
        f7 = w[31:25];
        ii = sx({20'd0, w[31:20]}, 12);
        is = sx({20'd0, w[31:25], w[11:7]}, 12);
        ib = sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        r = '0;
        known = 1'b1;
        mem = 1'b0;
        r.issued = 1'b1;
        r.entry_pc = pc;
        r.rob_dest = {27'd0, w[11:7]};
        case (w[6:0])
            OpcLui: begin
                r.rob_value = {w[31:12], 12'd0};
                r.value_ready = 1'b1;
            end
            OpcAuipc: begin
                r.rob_value = pc + {w[31:12], 12'd0};
                r.value_ready = 1'b1;
            end
            OpcJal: begin
                r.rob_value = pc + 32'd4;
                r.value_ready = 1'b1;
            end
            OpcJalr: begin
                known = (f3 == 3'd0);
                r.rob_kind = KindJalr;
                r.operand_form = FormRI;
                r.first_operand = w[19:15];
                r.second_operand = ii;
            end
            OpcBranch: begin
                r.rob_kind = KindBranch;
                r.rob_value = {31'd0, tk};
                r.rob_dest = pc + ib;
                r.first_operand = w[19:15];
                r.second_operand = {27'd0, w[24:20]};
                r.operand_form = FormRR;
                case (f3)
                    3'd0: r.station_op = SopEq;
                    3'd1: r.station_op = SopNe;
                    3'd4: r.station_op = SopLt;
                    3'd5: r.station_op = SopGe;
                    3'd6: r.station_op = SopLtu;
                    3'd7: r.station_op = SopGeu;
                    default: known = 1'b0;
                endcase
            end
            OpcLoad: begin
                mem = 1'b1;
                r.rob_value = {27'd0, lsu};
                r.operand_form = FormRI;
                r.first_operand = w[19:15];
                r.second_operand = ii;
                case (f3)
                    3'd0: r.station_op = SopLb;
                    3'd1: r.station_op = SopLh;
                    3'd2: r.station_op = SopLw;
                    3'd4: r.station_op = SopLbu;
                    3'd5: r.station_op = SopLhu;
                    default: known = 1'b0;
                endcase
            end
            OpcStore: begin
                known = (f3 <= 3'd2);
                mem = 1'b1;
                r.rob_kind = KindStoreB + f3;
                r.rob_value = {27'd0, lsu};
                r.station_op = SopSb + {2'd0, f3};
                r.operand_form = FormRRI;
                r.first_operand = w[24:20];
                r.second_operand = {27'd0, w[19:15]};
                r.third_operand = is;
            end
            OpcOpImm: begin
                r.operand_form = FormRI;
                r.first_operand = w[19:15];
                if (f3 == 3'd1 || f3 == F3Sra) begin
                    known = (f7 == 7'h00) || (f3 == F3Sra && f7 == F7Alt);
                    r.station_op = (f7 == F7Alt) ? SopSra : alu_code(f3);
                    r.second_operand = {27'd0, w[24:20]};
                end else begin
                    r.station_op = alu_code(f3);
                    r.second_operand = ii;
                end
            end
            OpcOp: begin
                r.operand_form = FormRR;
                r.first_operand = w[19:15];
                r.second_operand = {27'd0, w[24:20]};
                if (f7 == 7'h00) r.station_op = alu_code(f3);
                else if (f7 == F7Alt && f3 == 3'd0) r.station_op = SopSub;
                else if (f7 == F7Alt && f3 == F3Sra) r.station_op = SopSra;
                else known = 1'b0;
            end
            default: known = 1'b0;
        endcase
        if (w == ExitWord) begin
            r.rob_kind = KindExit;
            r.rob_value = '0;
            r.rob_dest = '0;
        end
    endfunction

    // Advance the queue model by one accepted item and queue its result
    task automatic step_queue();
        t_result res, tmp;
        logic known, mem, hb, tb;
        logic [IdxW-1:0] h, t;
        logic [31:0] pc, w;
        res = '0;
        h = head_ptr;
        t = tail_ptr;
        pc = pc_next;
        hb = q_valid[h];
        tb = q_valid[t];
        if (i_in.action) begin
            for (int k = 0; k < QueueDepth; k++) q_valid[k] = 1'b0;
            head_ptr = '0;
            tail_ptr = '0;
            pc_next = i_in.flush_target;
        end else begin
            // issue from head
            if (hb && i_in.rob_ready && i_in.station_ready) begin
                decode_word(q_word[h], q_pc[h], q_taken[h], i_in.lsu_slot, known, mem, tmp);
                if (known && (!mem || i_in.lsu_ready)) begin
                    res = tmp;
                    q_valid[h] = 1'b0;
                    head_ptr = h + 1'b1;
                end
            end
            // fetch into tail
            w = i_in.fetch_word;
            if (!tb) begin
                decode_word(w, pc, i_in.predict_taken, '0, known, mem, tmp);
                if (known) begin
                    q_valid[t] = 1'b1;
                    q_word[t] = w;
                    q_pc[t] = pc;
                    q_taken[t] = i_in.predict_taken;
                    if (w[6:0] == OpcBranch)
                        pc_next = i_in.predict_taken
                            ? pc + sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13)
                            : pc + 32'd4;
                    else if (w[6:0] == OpcJal)
                        pc_next = pc + sx({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
                    else
                        pc_next = pc + 32'd4;
                    tail_ptr = t + 1'b1;
                end
            end
        end
        res.fetch_pc = pc_next;
        expected_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            for (int k = 0; k < QueueDepth; k++) q_valid[k] = 1'b0;
            head_ptr = '0;
            tail_ptr = '0;
            pc_next = '0;
            expected_results.delete();
            fails = 0;
            o_pending = 0;
        end else begin
            // results first: a result never comes from the same-edge input
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                if (expected_results.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10) $display("unexpected result transfer %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails = fails + 1;
                        if (fails <= 10)
                            $display("result mismatch: expected %h got %h", want, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) step_queue();
            o_pending = expected_results.size();
        end
    end
endmodule

FILE: tb/sv/tb_fetch_queue_predict_dispatch_core.sv
// Top of the fetch queue / predict / dispatch testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on fqpd_pkg, fqpd_if and fqpd_queue_checker.
module tb_fetch_queue_predict_dispatch_core;
    import fqpd_pkg::*;

    localparam int RandomItems = 1500;
    localparam int IdleLimit = 2000;
    localparam int HoldCycles = 60;

    typedef enum logic {ActTick = 1'b0, ActFlush = 1'b1} t_action;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, idle_cycles;
    bit   stimulus_done = 0;
    bit   hold_off = 0;

    fqpd_in_if  in_ch();
    fqpd_out_if out_ch();

    fetch_queue_predict_dispatch_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    fqpd_queue_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Random instruction word; mostly decodable, some garbage
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        logic [6:0] opcs [9];
        w = $urandom();
        opcs = '{OpcLui, OpcAuipc, OpcJal, OpcJalr, OpcBranch, OpcLoad, OpcStore,
                 OpcOpImm, OpcOp};
        case ($urandom_range(0, 19))
            0: return w;
            1: return ExitWord;
            default: begin
                w[6:0] = opcs[$urandom_range(0, 8)];
                // keep funct7 legal often for shifts and register ops
                if ($urandom_range(0, 3) != 0 && (w[6:0] == OpcOp || w[6:0] == OpcOpImm))
                    w[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h00;
                if (w[6:0] == OpcJalr && $urandom_range(0, 3) != 0) w[14:12] = 3'd0;
                return w;
            end
        endcase
    endfunction

    // Offer one item; valid stays high into the next item when no gap is drawn
    task automatic send(input t_action act, input logic [31:0] w, input logic tk,
                        input logic rr, input logic sr, input logic lr,
                        input logic [4:0] slot, input logic [31:0] tgt);
        int idle;
        idle = $urandom_range(0, 3);
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.fetch_word <= w;
        in_ch.predict_taken <= tk;
        in_ch.rob_ready <= rr;
        in_ch.station_ready <= sr;
        in_ch.lsu_ready <= lr;
        in_ch.lsu_slot <= slot;
        in_ch.flush_target <= tgt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_rand(input int bias);
        logic busy;
        busy = ($urandom_range(0, 99) < bias);
        send($urandom_range(0, 60) == 0 ? ActFlush : ActTick, rand_word(),
             1'($urandom_range(0, 1)), busy | 1'($urandom_range(0, 1)),
             busy | 1'($urandom_range(0, 1)), busy | 1'($urandom_range(0, 1)),
             5'($urandom_range(0, 31)), $urandom());
    endtask

    // Receiver: random stalls, plus one long hold-off
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_off = 0;
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
            n = $urandom_range(0, 3);
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
    end

    // Watchdog on acceptance-free cycles
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit) begin
            $display("TEST FAILED");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ActTick;
        in_ch.fetch_word = '0;
        in_ch.predict_taken = 1'b0;
        in_ch.rob_ready = 1'b0;
        in_ch.station_ready = 1'b0;
        in_ch.lsu_ready = 1'b0;
        in_ch.lsu_slot = '0;
        in_ch.flush_target = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: fill with every kind, extremes, then flush
        send(ActTick, 32'h000002b7, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, '0);          // lui
        send(ActTick, 32'hfffff297, 1'b0, 1'b1, 1'b0, 1'b1, 5'd31, '1);         // auipc
        send(ActTick, 32'h00c5_8063, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, '0);         // beq taken
        send(ActTick, 32'hfe0f_9ee3, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, '0);         // bne back
        send(ActTick, 32'h0040_006f, 1'b0, 1'b1, 1'b1, 1'b1, 5'd0, '0);         // jal
        send(ActTick, 32'hfff0_8067, 1'b0, 1'b1, 1'b1, 1'b1, 5'd7, '0);         // jalr
        send(ActTick, 32'hffff_a083, 1'b1, 1'b1, 1'b1, 1'b0, 5'd31, '0);        // lw, lsu busy
        send(ActTick, 32'hfe1f_2fa3, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, '0);        // sw
        send(ActTick, 32'h41f0_5f93, 1'b0, 1'b1, 1'b1, 1'b1, 5'd3, '0);         // srai
        send(ActTick, 32'h01f0_9f93, 1'b0, 1'b1, 1'b1, 1'b1, 5'd3, '0);         // slli
        send(ActTick, 32'h4000_0033, 1'b0, 1'b1, 1'b1, 1'b1, 5'd0, '0);         // sub
        send(ActTick, ExitWord, 1'b1, 1'b1, 1'b1, 1'b1, 5'd0, '0);              // exit
        send(ActTick, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 5'd0, '0);         // unknown
        send(ActTick, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1, 5'd0, '0);         // unknown
        send(ActFlush, '1, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 32'hffff_fffc);
        // fill the queue until full with consumers blocked
        repeat (18) send(ActTick, 32'h0010_0093, 1'b0, 1'b0, 1'b1, 1'b1, 5'd0, '0);
        hold_off = 1;
        repeat (20) send(ActTick, rand_word(), 1'b0, 1'b1, 1'b1, 1'b1, 5'd0, '0);

        for (int n = 0; n < RandomItems; n++)
            send_rand(n < RandomItems / 2 ? 70 : 30);
        in_ch.valid <= 1'b0;
        stimulus_done = 1;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
